// ----- design/touch_point_calibrate_average_defines.svh -----
// Assertion macros used by the touch calibration top-level design file.
`ifndef TOUCH_POINT_CALIBRATE_AVERAGE_DEFINES_SVH
`define TOUCH_POINT_CALIBRATE_AVERAGE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TPCA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPCA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tpca_pkg.sv -----
// Shared types and constants of the touch calibration and averaging block.
package tpca_pkg;

    localparam int COORD_W           = 12;
    localparam int RAW_W             = 16;
    localparam int RAW_SHIFT         = 4;
    localparam int ORIENT_W          = 3;
    localparam int CFG_IDX_W         = 3;
    localparam int NUM_W             = 2 * COORD_W;
    localparam int DEFAULT_AVG_DEPTH = 4;

    localparam logic [COORD_W-1:0]  RST_X_MIN  = 12'd0;
    localparam logic [COORD_W-1:0]  RST_X_MAX  = 12'd4095;
    localparam logic [COORD_W-1:0]  RST_Y_MIN  = 12'd0;
    localparam logic [COORD_W-1:0]  RST_Y_MAX  = 12'd4095;
    localparam logic [COORD_W-1:0]  RST_WIDTH  = 12'd320;
    localparam logic [COORD_W-1:0]  RST_HEIGHT = 12'd480;
    localparam logic [ORIENT_W-1:0] RST_ORIENT = 3'd0;

    localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_FLAGS  = 3'd6;

    localparam int ORIENT_SWAP  = 0;
    localparam int ORIENT_INV_X = 1;
    localparam int ORIENT_INV_Y = 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SC_START,
        ST_SC_WAIT,
        ST_POST,
        ST_SUM,
        ST_AV_START,
        ST_AV_WAIT,
        ST_DONE
    } tpca_state_t;

    typedef struct packed {
        logic shift;
        logic accum;
    } tpca_cell_ctrl_t;

endpackage

// ----- design/tpca_divider.sv -----
// Restoring divider, one quotient bit per cycle, quotient known to fit 12 bits.
module tpca_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tpca_pkg::NUM_W-1:0]    num,
    input  logic [tpca_pkg::COORD_W-1:0]  den,
    output logic                          done,
    output logic [tpca_pkg::COORD_W-1:0]  quot
);

    localparam int CW     = tpca_pkg::COORD_W;
    localparam int STEP_W = $clog2(CW);

    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     rem_next;
    logic [CW-1:0]     low_reg;
    logic [CW-1:0]     low_next;
    logic [CW-1:0]     den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CW:0]       trial;
    logic              ge;

    always_comb begin
        trial    = {rem_reg, low_reg[CW-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? CW'(trial - {1'b0, den_reg}) : trial[CW-1:0];
        low_next = {low_reg[CW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(CW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[tpca_pkg::NUM_W-1:CW];
            low_reg <= num[CW-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

// ----- design/tpca_cell.sv -----
// One history cell: holds a point and passes a running sum to its neighbor.
module tpca_cell #(
    parameter int AVG_DEPTH = tpca_pkg::DEFAULT_AVG_DEPTH,
    parameter int IDX       = 0
) (
    input  logic                                                aclk,
    input  tpca_pkg::tpca_cell_ctrl_t                           ctrl,
    input  logic [$clog2(AVG_DEPTH+1)-1:0]                      fill,
    input  logic [tpca_pkg::COORD_W-1:0]                        prev_x,
    input  logic [tpca_pkg::COORD_W-1:0]                        prev_y,
    input  logic [tpca_pkg::COORD_W+$clog2(AVG_DEPTH+1)-1:0]    prev_sum_x,
    input  logic [tpca_pkg::COORD_W+$clog2(AVG_DEPTH+1)-1:0]    prev_sum_y,
    output logic [tpca_pkg::COORD_W-1:0]                        hist_x,
    output logic [tpca_pkg::COORD_W-1:0]                        hist_y,
    output logic [tpca_pkg::COORD_W+$clog2(AVG_DEPTH+1)-1:0]    sum_x,
    output logic [tpca_pkg::COORD_W+$clog2(AVG_DEPTH+1)-1:0]    sum_y
);

    localparam int FILL_W = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W  = tpca_pkg::COORD_W + FILL_W;

    logic [tpca_pkg::COORD_W-1:0] hist_x_reg;
    logic [tpca_pkg::COORD_W-1:0] hist_y_reg;
    logic [SUM_W-1:0]             sum_x_reg;
    logic [SUM_W-1:0]             sum_y_reg;
    logic                         live;

    assign live = FILL_W'(IDX) < fill;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            hist_x_reg <= prev_x;
            hist_y_reg <= prev_y;
        end
        if (ctrl.accum) begin
            sum_x_reg <= prev_sum_x + (live ? SUM_W'(hist_x_reg) : '0);
            sum_y_reg <= prev_sum_y + (live ? SUM_W'(hist_y_reg) : '0);
        end
    end

    assign hist_x = hist_x_reg;
    assign hist_y = hist_y_reg;
    assign sum_x  = sum_x_reg;
    assign sum_y  = sum_y_reg;

endmodule

// ----- design/touch_point_calibrate_average.sv -----
// Touch calibration: scale raw readings to screen and average recent points.
// Pen-down path: a scaling multiply, then two 12-step divisions per axis (scaling,
// then averaging) around a summing pass over the history cells; pen-up goes to output.
// One item at a time: the next is taken only once the current result is loaded
// into the output, which holds while an earlier result still waits there.
// Synchronous reset restores register defaults, clears fill count and held point.
`include "touch_point_calibrate_average_defines.svh"
module touch_point_calibrate_average #(
    parameter int AVG_DEPTH = tpca_pkg::DEFAULT_AVG_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tpca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpca_pkg::COORD_W-1:0]    cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // raw_x_word, raw_y_word
    input  logic                            s_tuser,   // pen_down
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // point_x, point_y
    output logic                            m_tuser    // pressed
);

    localparam int CW     = tpca_pkg::COORD_W;
    localparam int RW     = tpca_pkg::RAW_W;
    localparam int FILL_W = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W  = CW + FILL_W;
    localparam int NW     = tpca_pkg::NUM_W;

    logic [CW-1:0]                   x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [CW-1:0]                   width_reg, height_reg;
    logic [tpca_pkg::ORIENT_W-1:0]   orient_reg;

    tpca_pkg::tpca_state_t           state_reg, state_next;
    logic [FILL_W-1:0]               fill_reg;
    logic [FILL_W-1:0]               sum_cnt_reg;
    logic [CW-1:0]                   held_x_reg, held_y_reg;
    logic                            pressed_reg;
    logic [CW-1:0]                   off_x_reg, off_y_reg, span_x_reg, span_y_reg;
    logic                            sat_x_reg, sat_y_reg;
    logic [NW-1:0]                   prod_x_reg, prod_y_reg;
    logic                            m_tvalid_reg;
    logic [CW-1:0]                   m_x_reg, m_y_reg;
    logic                            m_pressed_reg;

    logic                            in_xfer;
    logic                            out_load;
    logic                            div_start;
    logic                            div_sel_avg;
    tpca_pkg::tpca_cell_ctrl_t       cell_ctrl;

    logic [CW-1:0]                   raw_a, raw_b, rx, ry;
    logic [CW-1:0]                   off_x, off_y, span_x, span_y;
    logic [CW-1:0]                   v_x, v_y, sample_x, sample_y;
    logic [NW-1:0]                   num_x, num_y;
    logic [CW-1:0]                   den_x, den_y;
    logic                            div_done_x, div_done_y;
    logic [CW-1:0]                   quot_x, quot_y;

    logic [CW-1:0]                   chain_x   [AVG_DEPTH+1];
    logic [CW-1:0]                   chain_y   [AVG_DEPTH+1];
    logic [SUM_W-1:0]                chain_sx  [AVG_DEPTH+1];
    logic [SUM_W-1:0]                chain_sy  [AVG_DEPTH+1];

    assign in_xfer = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg  <= tpca_pkg::RST_X_MIN;
            x_max_reg  <= tpca_pkg::RST_X_MAX;
            y_min_reg  <= tpca_pkg::RST_Y_MIN;
            y_max_reg  <= tpca_pkg::RST_Y_MAX;
            width_reg  <= tpca_pkg::RST_WIDTH;
            height_reg <= tpca_pkg::RST_HEIGHT;
            orient_reg <= tpca_pkg::RST_ORIENT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tpca_pkg::REG_X_RAW_MIN:     x_min_reg  <= cfg_data;
                tpca_pkg::REG_X_RAW_MAX:     x_max_reg  <= cfg_data;
                tpca_pkg::REG_Y_RAW_MIN:     y_min_reg  <= cfg_data;
                tpca_pkg::REG_Y_RAW_MAX:     y_max_reg  <= cfg_data;
                tpca_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                tpca_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                tpca_pkg::REG_ORIENT_FLAGS:  orient_reg <= cfg_data[tpca_pkg::ORIENT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        raw_a  = s_tdata[RW-1:tpca_pkg::RAW_SHIFT];
        raw_b  = s_tdata[2*RW-1:RW+tpca_pkg::RAW_SHIFT];
        rx     = orient_reg[tpca_pkg::ORIENT_SWAP] ? raw_b : raw_a;
        ry     = orient_reg[tpca_pkg::ORIENT_SWAP] ? raw_a : raw_b;
        off_x  = (rx > x_min_reg) ? rx - x_min_reg : '0;
        off_y  = (ry > y_min_reg) ? ry - y_min_reg : '0;
        span_x = (x_max_reg > x_min_reg) ? x_max_reg - x_min_reg : '0;
        span_y = (y_max_reg > y_min_reg) ? y_max_reg - y_min_reg : '0;
    end

    always_comb begin
        v_x      = sat_x_reg ? width_reg : quot_x;
        v_y      = sat_y_reg ? height_reg : quot_y;
        sample_x = orient_reg[tpca_pkg::ORIENT_INV_X] ? width_reg - v_x : v_x;
        sample_y = orient_reg[tpca_pkg::ORIENT_INV_Y] ? height_reg - v_y : v_y;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tpca_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = s_tuser ? tpca_pkg::ST_MUL : tpca_pkg::ST_DONE;
                end
            end
            tpca_pkg::ST_MUL:      state_next = tpca_pkg::ST_SC_START;
            tpca_pkg::ST_SC_START: state_next = tpca_pkg::ST_SC_WAIT;
            tpca_pkg::ST_SC_WAIT: begin
                if (div_done_x) begin
                    state_next = tpca_pkg::ST_POST;
                end
            end
            tpca_pkg::ST_POST:     state_next = tpca_pkg::ST_SUM;
            tpca_pkg::ST_SUM: begin
                if (sum_cnt_reg == FILL_W'(AVG_DEPTH - 1)) begin
                    state_next = tpca_pkg::ST_AV_START;
                end
            end
            tpca_pkg::ST_AV_START: state_next = tpca_pkg::ST_AV_WAIT;
            tpca_pkg::ST_AV_WAIT: begin
                if (div_done_x) begin
                    state_next = tpca_pkg::ST_DONE;
                end
            end
            tpca_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = tpca_pkg::ST_IDLE;
                end
            end
            default: state_next = tpca_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        div_start       = 1'b0;
        div_sel_avg     = 1'b0;
        cell_ctrl.shift = 1'b0;
        cell_ctrl.accum = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            tpca_pkg::ST_IDLE:     s_tready = 1'b1;
            tpca_pkg::ST_SC_START: div_start = 1'b1;
            tpca_pkg::ST_POST:     cell_ctrl.shift = 1'b1;
            tpca_pkg::ST_SUM:      cell_ctrl.accum = 1'b1;
            tpca_pkg::ST_AV_START: begin
                div_start   = 1'b1;
                div_sel_avg = 1'b1;
            end
            tpca_pkg::ST_DONE:     out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tpca_pkg::ST_IDLE;
            fill_reg     <= '0;
            held_x_reg   <= '0;
            held_y_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            sum_cnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (in_xfer && !s_tuser) begin
                fill_reg <= '0;
            end else if (state_reg == tpca_pkg::ST_POST) begin
                sum_cnt_reg <= '0;
                if (fill_reg != FILL_W'(AVG_DEPTH)) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
            if (state_reg == tpca_pkg::ST_SUM) begin
                sum_cnt_reg <= sum_cnt_reg + FILL_W'(1);
            end
            if (state_reg == tpca_pkg::ST_AV_WAIT && div_done_x) begin
                held_x_reg <= quot_x;
                held_y_reg <= quot_y;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            pressed_reg <= s_tuser;
            off_x_reg   <= off_x;
            off_y_reg   <= off_y;
            span_x_reg  <= span_x;
            span_y_reg  <= span_y;
            sat_x_reg   <= off_x >= span_x;
            sat_y_reg   <= off_y >= span_y;
        end
        if (state_reg == tpca_pkg::ST_MUL) begin
            prod_x_reg <= off_x_reg * width_reg;
            prod_y_reg <= off_y_reg * height_reg;
        end
        if (out_load) begin
            m_x_reg       <= held_x_reg;
            m_y_reg       <= held_y_reg;
            m_pressed_reg <= pressed_reg;
        end
    end

    always_comb begin
        num_x = div_sel_avg ? NW'(chain_sx[AVG_DEPTH]) : prod_x_reg;
        num_y = div_sel_avg ? NW'(chain_sy[AVG_DEPTH]) : prod_y_reg;
        den_x = div_sel_avg ? CW'(fill_reg) : span_x_reg;
        den_y = div_sel_avg ? CW'(fill_reg) : span_y_reg;
    end

    tpca_divider u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_x),
        .den     (den_x),
        .done    (div_done_x),
        .quot    (quot_x)
    );

    tpca_divider u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_y),
        .den     (den_y),
        .done    (div_done_y),
        .quot    (quot_y)
    );

    assign chain_x[0]  = sample_x;
    assign chain_y[0]  = sample_y;
    assign chain_sx[0] = '0;
    assign chain_sy[0] = '0;

    for (genvar i = 0; i < AVG_DEPTH; i++) begin : g_cell
        tpca_cell #(
            .AVG_DEPTH (AVG_DEPTH),
            .IDX       (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .fill       (fill_reg),
            .prev_x     (chain_x[i]),
            .prev_y     (chain_y[i]),
            .prev_sum_x (chain_sx[i]),
            .prev_sum_y (chain_sy[i]),
            .hist_x     (chain_x[i+1]),
            .hist_y     (chain_y[i+1]),
            .sum_x      (chain_sx[i+1]),
            .sum_y      (chain_sy[i+1])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_y_reg, m_x_reg};
    assign m_tuser  = m_pressed_reg;

    `TPCA_ASSERT_NOW(a_div_lockstep, 1'b1, div_done_x == div_done_y,
        "axis dividers out of step")
    `TPCA_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(AVG_DEPTH),
        "fill count above averaging depth")
    `TPCA_ASSERT_NOW(a_done_in_wait, div_done_x,
        state_reg == tpca_pkg::ST_SC_WAIT || state_reg == tpca_pkg::ST_AV_WAIT,
        "divider finished outside a wait state")
    `TPCA_ASSERT_NEXT(a_one_in_flight, in_xfer, !s_tready,
        "second transfer taken while an item is in flight")

endmodule
